@@ sv/joystick_omni_drive_mapper_unit_macros.svh @@
// Assertion macros for the joystick omni-drive mapper.
// Included by the top level; no other dependencies.
`ifndef JOYSTICK_OMNI_DRIVE_MAPPER_UNIT_MACROS_SVH
`define JOYSTICK_OMNI_DRIVE_MAPPER_UNIT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define JODM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define JODM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/jodm_pkg.sv @@
// Shared types and constants of the joystick omni-drive mapper.
// No dependencies; used by every module of the block.
package jodm_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W   = 10;
    localparam int DUTY_W     = 10;
    localparam int DRIVE_W    = 2;
    localparam int THR_W      = 11;
    localparam int SCALE_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int MUL_IN_W   = 21;
    localparam int MUL_OUT_W  = 42;
    localparam int R2_W       = 21;
    localparam int RHS_W      = 36;
    localparam int NUM_W      = 18;
    localparam int QUO_W      = 10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_DEADBAND  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX       = 3'd6;

    // Configuration reset values
    localparam logic [SAMPLE_W-1:0] RST_CENTER_X       = 10'd499;
    localparam logic [SAMPLE_W-1:0] RST_CENTER_Y       = 10'd504;
    localparam logic [THR_W-1:0]    RST_MOVE_THRESHOLD = 11'd15;
    localparam logic [SCALE_W-1:0]  RST_SPEED_SCALE    = 8'd10;
    localparam logic [SAMPLE_W-1:0] RST_AXIS_DEADBAND  = 10'd15;
    localparam logic [DUTY_W-1:0]   RST_DUTY_MIN       = 10'd250;
    localparam logic [DUTY_W-1:0]   RST_DUTY_MAX       = 10'd1023;

    // Motor pair direction codes
    localparam logic [DRIVE_W-1:0] DRIVE_STOP = 2'd0;
    localparam logic [DRIVE_W-1:0] DRIVE_FWD  = 2'd1;
    localparam logic [DRIVE_W-1:0] DRIVE_REV  = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] center_x;
        logic [SAMPLE_W-1:0] center_y;
        logic [THR_W-1:0]    move_threshold;
        logic [SCALE_W-1:0]  speed_scale;
        logic [SAMPLE_W-1:0] axis_deadband;
        logic [DUTY_W-1:0]   duty_min;
        logic [DUTY_W-1:0]   duty_max;
    } t_cfg;

    // Operands for the shared multiply/compare unit
    typedef struct packed {
        logic [MUL_IN_W-1:0]  a;
        logic [MUL_IN_W-1:0]  b;
        logic [MUL_OUT_W-1:0] cmp_val;
    } t_mul_op;

    // Result handed from the sequencer to the top level
    typedef struct packed {
        logic              done;
        logic              run;
        logic [DUTY_W-1:0] x_duty;
        logic [DUTY_W-1:0] y_duty;
        logic              x_fwd;
        logic              x_rev;
        logic              y_fwd;
        logic              y_rev;
    } t_seq_res;

endpackage

@@ sv/jodm_mulcmp.sv @@
// Shared multiply/compare unit: registered product, compare against a limit.
// Depends on jodm_pkg.
module jodm_mulcmp (
    input  logic                           i_clk,
    input  jodm_pkg::t_mul_op              i_op,
    output logic [jodm_pkg::MUL_OUT_W-1:0] o_prod,
    output logic                           o_le
);

    logic [jodm_pkg::MUL_OUT_W-1:0] r_prod;
    logic [jodm_pkg::MUL_OUT_W-1:0] n_prod;

    // Form the product of the two operands
    always_comb begin
        n_prod = {{(jodm_pkg::MUL_OUT_W-jodm_pkg::MUL_IN_W){1'b0}}, i_op.a}
               * {{(jodm_pkg::MUL_OUT_W-jodm_pkg::MUL_IN_W){1'b0}}, i_op.b};
    end

    // Register the product
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    // Compare the held product against the limit
    assign o_prod = r_prod;
    assign o_le   = (r_prod <= i_op.cmp_val);

endmodule

@@ sv/jodm_seq.sv @@
// Sequencer of the mapper: radius test, quotient search and duty division,
// all through one shared multiply/compare unit. Depends on jodm_pkg, jodm_mulcmp.
module jodm_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [jodm_pkg::SAMPLE_W-1:0]     i_x_sample,
    input  logic [jodm_pkg::SAMPLE_W-1:0]     i_y_sample,
    input  jodm_pkg::t_cfg                    i_cfg,
    input  logic                              i_ack,
    output jodm_pkg::t_seq_res                o_res
);

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] S_IDLE = 5'd0;
    localparam logic [ST_W-1:0] S_SQX  = 5'd1;
    localparam logic [ST_W-1:0] S_SQY  = 5'd2;
    localparam logic [ST_W-1:0] S_THR  = 5'd3;
    localparam logic [ST_W-1:0] S_TCMP = 5'd4;
    localparam logic [ST_W-1:0] S_SD   = 5'd5;
    localparam logic [ST_W-1:0] S_SQ2  = 5'd6;
    localparam logic [ST_W-1:0] S_RHS  = 5'd7;
    localparam logic [ST_W-1:0] S_TT   = 5'd8;
    localparam logic [ST_W-1:0] S_TR   = 5'd9;
    localparam logic [ST_W-1:0] S_TC   = 5'd10;
    localparam logic [ST_W-1:0] S_NUM  = 5'd11;
    localparam logic [ST_W-1:0] S_NSV  = 5'd12;
    localparam logic [ST_W-1:0] S_DT   = 5'd13;
    localparam logic [ST_W-1:0] S_DC   = 5'd14;
    localparam logic [ST_W-1:0] S_DUTY = 5'd15;
    localparam logic [ST_W-1:0] S_DONE = 5'd16;

    localparam logic [3:0] Q_TOP_BIT   = 4'd7;
    localparam logic [3:0] QUO_TOP_BIT = 4'd9;

    // Control state
    logic [ST_W-1:0] r_state, n_state;
    logic            r_axis, n_axis;
    logic [3:0]      r_bit, n_bit;

    // Working values
    logic [jodm_pkg::SAMPLE_W-1:0] r_dx_mag, n_dx_mag, r_dy_mag, n_dy_mag;
    logic                          r_dx_neg, n_dx_neg, r_dy_neg, n_dy_neg;
    logic [jodm_pkg::R2_W-1:0]     r_r2, n_r2;
    logic [jodm_pkg::RHS_W-1:0]    r_rhs, n_rhs;
    logic [jodm_pkg::SCALE_W-1:0]  r_q, n_q;
    logic [jodm_pkg::NUM_W-1:0]    r_num, n_num;
    logic [jodm_pkg::QUO_W-1:0]    r_quo, n_quo;
    logic [jodm_pkg::DUTY_W-1:0]   r_x_duty, n_x_duty, r_y_duty, n_y_duty;
    logic                          r_run, n_run;

    // Combinational helpers
    logic [jodm_pkg::SAMPLE_W:0]   dx_full, dy_full, dx_negd, dy_negd;
    logic [jodm_pkg::DUTY_W:0]     span_full, span_negd;
    logic                          span_neg;
    logic [jodm_pkg::DUTY_W-1:0]   span_mag;
    logic [jodm_pkg::SAMPLE_W-1:0] cur_mag;
    logic [jodm_pkg::SCALE_W-1:0]  trial_q;
    logic [jodm_pkg::QUO_W-1:0]    trial_quo;
    logic [jodm_pkg::DUTY_W-1:0]   duty_val;
    logic                          r2_above;

    jodm_pkg::t_mul_op              mul_op;
    logic [jodm_pkg::MUL_OUT_W-1:0] prod;
    logic                           prod_le;

    jodm_mulcmp u_mulcmp (
        .i_clk  (i_clk),
        .i_op   (mul_op),
        .o_prod (prod),
        .o_le   (prod_le)
    );

    // Split deflections and duty span into sign and magnitude
    always_comb begin
        dx_full   = {1'b0, i_x_sample} - {1'b0, i_cfg.center_x};
        dy_full   = {1'b0, i_y_sample} - {1'b0, i_cfg.center_y};
        dx_negd   = ~dx_full + 11'd1;
        dy_negd   = ~dy_full + 11'd1;
        span_full = {1'b0, i_cfg.duty_max} - {1'b0, i_cfg.duty_min};
        span_negd = ~span_full + 11'd1;
        span_neg  = span_full[jodm_pkg::DUTY_W];
        span_mag  = span_neg ? span_negd[jodm_pkg::DUTY_W-1:0]
                             : span_full[jodm_pkg::DUTY_W-1:0];
        cur_mag   = r_axis ? r_dy_mag : r_dx_mag;
        trial_q   = r_q | (8'd1 << r_bit[2:0]);
        trial_quo = r_quo | (10'd1 << r_bit);
        duty_val  = span_neg ? (i_cfg.duty_min - r_quo) : (i_cfg.duty_min + r_quo);
        r2_above  = (r_r2 > prod[jodm_pkg::R2_W-1:0]);
    end

    // Steer operands into the shared unit
    always_comb begin
        mul_op = '0;
        unique case (r_state)
            S_SQX: begin
                mul_op.a = {11'd0, r_dx_mag};
                mul_op.b = {11'd0, r_dx_mag};
            end
            S_SQY: begin
                mul_op.a = {11'd0, r_dy_mag};
                mul_op.b = {11'd0, r_dy_mag};
            end
            S_THR: begin
                mul_op.a = {10'd0, i_cfg.move_threshold};
                mul_op.b = {10'd0, i_cfg.move_threshold};
            end
            S_SD: begin
                mul_op.a = {13'd0, i_cfg.speed_scale};
                mul_op.b = {11'd0, cur_mag};
            end
            S_SQ2: begin
                mul_op.a = {3'd0, prod[jodm_pkg::NUM_W-1:0]};
                mul_op.b = {3'd0, prod[jodm_pkg::NUM_W-1:0]};
            end
            S_TT: begin
                mul_op.a = {13'd0, trial_q};
                mul_op.b = {13'd0, trial_q};
            end
            S_TR: begin
                mul_op.a = {5'd0, prod[15:0]};
                mul_op.b = r_r2;
            end
            S_TC: begin
                mul_op.cmp_val = {6'd0, r_rhs};
            end
            S_NUM: begin
                mul_op.a = {13'd0, r_q};
                mul_op.b = {11'd0, span_mag};
            end
            S_DT: begin
                mul_op.a = {11'd0, trial_quo};
                mul_op.b = {13'd0, i_cfg.speed_scale};
            end
            S_DC: begin
                mul_op.cmp_val = {24'd0, r_num};
            end
            default: begin
                mul_op = '0;
            end
        endcase
    end

    // Advance the sequencer
    always_comb begin
        n_state  = r_state;
        n_axis   = r_axis;
        n_bit    = r_bit;
        n_dx_mag = r_dx_mag;
        n_dy_mag = r_dy_mag;
        n_dx_neg = r_dx_neg;
        n_dy_neg = r_dy_neg;
        n_r2     = r_r2;
        n_rhs    = r_rhs;
        n_q      = r_q;
        n_num    = r_num;
        n_quo    = r_quo;
        n_x_duty = r_x_duty;
        n_y_duty = r_y_duty;
        n_run    = r_run;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_dx_neg = dx_full[jodm_pkg::SAMPLE_W];
                    n_dy_neg = dy_full[jodm_pkg::SAMPLE_W];
                    n_dx_mag = dx_full[jodm_pkg::SAMPLE_W] ? dx_negd[jodm_pkg::SAMPLE_W-1:0]
                                                          : dx_full[jodm_pkg::SAMPLE_W-1:0];
                    n_dy_mag = dy_full[jodm_pkg::SAMPLE_W] ? dy_negd[jodm_pkg::SAMPLE_W-1:0]
                                                          : dy_full[jodm_pkg::SAMPLE_W-1:0];
                    n_state  = S_SQX;
                end
            end
            S_SQX: n_state = S_SQY;
            S_SQY: begin
                n_r2    = prod[jodm_pkg::R2_W-1:0];
                n_state = S_THR;
            end
            S_THR: begin
                n_r2    = r_r2 + prod[jodm_pkg::R2_W-1:0];
                n_state = S_TCMP;
            end
            S_TCMP: begin
                // Drop to the result when inside the deadzone or when the speed scale is zero
                n_run = r2_above;
                if (!r2_above) begin
                    n_state = S_DONE;
                end else if (i_cfg.speed_scale == '0) begin
                    n_x_duty = i_cfg.duty_min;
                    n_y_duty = i_cfg.duty_min;
                    n_state  = S_DONE;
                end else begin
                    n_axis  = 1'b0;
                    n_state = S_SD;
                end
            end
            S_SD:  n_state = S_SQ2;
            S_SQ2: n_state = S_RHS;
            S_RHS: begin
                n_rhs   = prod[jodm_pkg::RHS_W-1:0];
                n_q     = '0;
                n_bit   = Q_TOP_BIT;
                n_state = S_TT;
            end
            S_TT: n_state = S_TR;
            S_TR: n_state = S_TC;
            S_TC: begin
                // Keep the trial bit when q^2 * r2 still fits under scale^2 * d^2
                if (prod_le) begin
                    n_q = trial_q;
                end
                if (r_bit == '0) begin
                    n_state = S_NUM;
                end else begin
                    n_bit   = r_bit - 4'd1;
                    n_state = S_TT;
                end
            end
            S_NUM: n_state = S_NSV;
            S_NSV: begin
                n_num   = prod[jodm_pkg::NUM_W-1:0];
                n_quo   = '0;
                n_bit   = QUO_TOP_BIT;
                n_state = S_DT;
            end
            S_DT: n_state = S_DC;
            S_DC: begin
                // Keep the trial bit when quotient times scale fits under the numerator
                if (prod_le) begin
                    n_quo = trial_quo;
                end
                if (r_bit == '0) begin
                    n_state = S_DUTY;
                end else begin
                    n_bit   = r_bit - 4'd1;
                    n_state = S_DT;
                end
            end
            S_DUTY: begin
                if (!r_axis) begin
                    n_x_duty = duty_val;
                    n_axis   = 1'b1;
                    n_state  = S_SD;
                end else begin
                    n_y_duty = duty_val;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= 1'b0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_bit   <= n_bit;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_dx_mag <= n_dx_mag;
        r_dy_mag <= n_dy_mag;
        r_dx_neg <= n_dx_neg;
        r_dy_neg <= n_dy_neg;
        r_r2     <= n_r2;
        r_rhs    <= n_rhs;
        r_q      <= n_q;
        r_num    <= n_num;
        r_quo    <= n_quo;
        r_x_duty <= n_x_duty;
        r_y_duty <= n_y_duty;
        r_run    <= n_run;
    end

    // Report the finished transaction
    always_comb begin
        o_res.done   = (r_state == S_DONE);
        o_res.run    = r_run;
        o_res.x_duty = r_x_duty;
        o_res.y_duty = r_y_duty;
        o_res.x_fwd  = !r_dx_neg && (r_dx_mag > i_cfg.axis_deadband);
        o_res.x_rev  = r_dx_neg && (r_dx_mag > i_cfg.axis_deadband);
        o_res.y_fwd  = !r_dy_neg && (r_dy_mag > i_cfg.axis_deadband);
        o_res.y_rev  = r_dy_neg && (r_dy_mag > i_cfg.axis_deadband);
    end

endmodule

@@ sv/joystick_omni_drive_mapper_unit.sv @@
// Joystick omni-drive mapper. One transaction on the input channel carries an x and
// y sample; one transaction on the output channel returns both duties and both
// direction codes. Work runs through a single shared 21x21 multiplier with a
// registered product, stepped by a sequencer: out of the deadzone it runs two
// 8-step quotient searches and two 10-step divisions, one of each per axis;
// inside the deadzone or with a zero speed scale it skips them. One transaction
// is in work at a time; the next is accepted in the cycle after the result
// moves to the output register, even while that result still waits to be taken.
// Depends on jodm_pkg, jodm_seq and the assertion macro header.
`include "joystick_omni_drive_mapper_unit_macros.svh"

module joystick_omni_drive_mapper_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [jodm_pkg::SAMPLE_W-1:0]      i_x_sample,
    input  logic [jodm_pkg::SAMPLE_W-1:0]      i_y_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [jodm_pkg::DUTY_W-1:0]        o_x_duty,
    output logic [jodm_pkg::DUTY_W-1:0]        o_y_duty,
    output logic [jodm_pkg::DRIVE_W-1:0]       o_x_drive,
    output logic [jodm_pkg::DRIVE_W-1:0]       o_y_drive,
    input  logic                               i_cfg_we,
    input  logic [jodm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [jodm_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    jodm_pkg::t_cfg     r_cfg;
    jodm_pkg::t_seq_res w_res;

    logic r_busy;
    logic r_out_valid;
    logic [jodm_pkg::DUTY_W-1:0]  r_held_x_duty, r_held_y_duty;
    logic [jodm_pkg::DRIVE_W-1:0] r_held_x_drive, r_held_y_drive;

    logic in_accept;
    logic ack;

    assign o_in_ready = !r_busy;
    assign in_accept  = i_in_valid && !r_busy;
    assign ack        = w_res.done && (!r_out_valid || i_out_ready);

    jodm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_accept),
        .i_x_sample (i_x_sample),
        .i_y_sample (i_y_sample),
        .i_cfg      (r_cfg),
        .i_ack      (ack),
        .o_res      (w_res)
    );

    // Write configuration registers; ignore indexes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x       <= jodm_pkg::RST_CENTER_X;
            r_cfg.center_y       <= jodm_pkg::RST_CENTER_Y;
            r_cfg.move_threshold <= jodm_pkg::RST_MOVE_THRESHOLD;
            r_cfg.speed_scale    <= jodm_pkg::RST_SPEED_SCALE;
            r_cfg.axis_deadband  <= jodm_pkg::RST_AXIS_DEADBAND;
            r_cfg.duty_min       <= jodm_pkg::RST_DUTY_MIN;
            r_cfg.duty_max       <= jodm_pkg::RST_DUTY_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                jodm_pkg::REG_CENTER_X:       r_cfg.center_x       <= i_cfg_wdata[9:0];
                jodm_pkg::REG_CENTER_Y:       r_cfg.center_y       <= i_cfg_wdata[9:0];
                jodm_pkg::REG_MOVE_THRESHOLD: r_cfg.move_threshold <= i_cfg_wdata;
                jodm_pkg::REG_SPEED_SCALE:    r_cfg.speed_scale    <= i_cfg_wdata[7:0];
                jodm_pkg::REG_AXIS_DEADBAND:  r_cfg.axis_deadband  <= i_cfg_wdata[9:0];
                jodm_pkg::REG_DUTY_MIN:       r_cfg.duty_min       <= i_cfg_wdata[9:0];
                jodm_pkg::REG_DUTY_MAX:       r_cfg.duty_max       <= i_cfg_wdata[9:0];
                default: begin
                end
            endcase
        end
    end

    // Track the transaction in work
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_accept) begin
            r_busy <= 1'b1;
        end else if (ack) begin
            r_busy <= 1'b0;
        end
    end

    // Update held state and the output register when a result is taken over; clear valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_held_x_duty  <= '0;
            r_held_y_duty  <= '0;
            r_held_x_drive <= jodm_pkg::DRIVE_STOP;
            r_held_y_drive <= jodm_pkg::DRIVE_STOP;
        end else begin
            if (ack) begin
                r_out_valid <= 1'b1;
                if (w_res.run) begin
                    r_held_x_duty <= w_res.x_duty;
                    r_held_y_duty <= w_res.y_duty;
                    if (w_res.x_fwd) begin
                        r_held_x_drive <= jodm_pkg::DRIVE_FWD;
                    end else if (w_res.x_rev) begin
                        r_held_x_drive <= jodm_pkg::DRIVE_REV;
                    end
                    if (w_res.y_fwd) begin
                        r_held_y_drive <= jodm_pkg::DRIVE_FWD;
                    end else if (w_res.y_rev) begin
                        r_held_y_drive <= jodm_pkg::DRIVE_REV;
                    end
                end else begin
                    r_held_x_drive <= jodm_pkg::DRIVE_STOP;
                    r_held_y_drive <= jodm_pkg::DRIVE_STOP;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_x_duty    = r_held_x_duty;
    assign o_y_duty    = r_held_y_duty;
    assign o_x_drive   = r_held_x_drive;
    assign o_y_drive   = r_held_y_drive;

    // Checks on sequencing and result handling
    `JODM_ASSERT_SAME(a_done_only_busy, i_clk, i_rst_n, w_res.done, r_busy, "result without transaction")
    `JODM_ASSERT_NEXT(a_ack_shows_result, i_clk, i_rst_n, ack, o_out_valid, "result not presented")
    `JODM_ASSERT_NEXT(a_deadzone_stops, i_clk, i_rst_n, ack && !w_res.run, (o_x_drive == jodm_pkg::DRIVE_STOP) && (o_y_drive == jodm_pkg::DRIVE_STOP), "deadzone did not stop drives")
    `JODM_ASSERT_SAME(a_zero_scale_min, i_clk, i_rst_n, w_res.done && w_res.run && (r_cfg.speed_scale == '0), (w_res.x_duty == r_cfg.duty_min) && (w_res.y_duty == r_cfg.duty_min), "zero scale duty not minimum")

endmodule

@@ verif/omni_drive_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the joystick omni-drive mapper: watches the sample, result and
// register ports, predicts duties and directions, and compares every transaction.
// Depends on jodm_pkg only.
module omni_drive_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [jodm_pkg::SAMPLE_W-1:0]   i_x_sample,
    input  logic [jodm_pkg::SAMPLE_W-1:0]   i_y_sample,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [jodm_pkg::DUTY_W-1:0]     i_x_duty,
    input  logic [jodm_pkg::DUTY_W-1:0]     i_y_duty,
    input  logic [jodm_pkg::DRIVE_W-1:0]    i_x_drive,
    input  logic [jodm_pkg::DRIVE_W-1:0]    i_y_drive,
    input  logic                            i_cfg_we,
    input  logic [jodm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [jodm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                              o_mismatches,
    output int                              o_outstanding,
    output int                              o_checked
);
    import jodm_pkg::*;

    typedef struct packed {
        logic [DUTY_W-1:0]  x_duty;
        logic [DUTY_W-1:0]  y_duty;
        logic [DRIVE_W-1:0] x_drive;
        logic [DRIVE_W-1:0] y_drive;
    } t_drive_cmd;

    t_cfg               settings;
    logic [DUTY_W-1:0]  held_x_duty;
    logic [DUTY_W-1:0]  held_y_duty;
    logic [DRIVE_W-1:0] held_x_drive;
    logic [DRIVE_W-1:0] held_y_drive;
    t_drive_cmd         pending_cmds[$];
    t_drive_cmd         want;
    t_drive_cmd         seen;

    // Largest step count q with q*q*r2 <= scale*scale*d*d (exact speed quantizer)
    function automatic longint speed_steps(input longint d, input longint r2,
                                           input longint scale);
        longint mag;
        longint q;
        mag = (d < 0) ? -d : d;
        q = scale;
        while (q > 0 && q * q * r2 > scale * scale * mag * mag)
            q--;
        return q;
    endfunction

    // Duty for a step count; signed division truncates toward zero
    function automatic logic [DUTY_W-1:0] duty_for(input longint q);
        longint lo;
        longint hi;
        longint scale;
        longint v;
        lo = longint'(settings.duty_min);
        hi = longint'(settings.duty_max);
        scale = longint'(settings.speed_scale);
        if (scale == 0)
            return settings.duty_min;
        v = lo + (q * (hi - lo)) / scale;
        return v[DUTY_W-1:0];
    endfunction

    // Direction is set outside the deadband, otherwise the held one stays
    function automatic logic [DRIVE_W-1:0] drive_for(input longint d, input longint band,
                                                     input logic [DRIVE_W-1:0] held);
        if (d > band)
            return DRIVE_FWD;
        if (d < -band)
            return DRIVE_REV;
        return held;
    endfunction

    // Advance the held state by one sample pair and return the command it gives
    function automatic t_drive_cmd next_drive_cmd(input logic [SAMPLE_W-1:0] xs,
                                                  input logic [SAMPLE_W-1:0] ys);
        longint dx;
        longint dy;
        longint r2;
        longint thr;
        t_drive_cmd cmd;
        dx = longint'(xs) - longint'(settings.center_x);
        dy = longint'(ys) - longint'(settings.center_y);
        r2 = dx * dx + dy * dy;
        thr = longint'(settings.move_threshold);
        if (r2 > thr * thr) begin
            held_x_duty  = duty_for(speed_steps(dx, r2, longint'(settings.speed_scale)));
            held_y_duty  = duty_for(speed_steps(dy, r2, longint'(settings.speed_scale)));
            held_x_drive = drive_for(dx, longint'(settings.axis_deadband), held_x_drive);
            held_y_drive = drive_for(dy, longint'(settings.axis_deadband), held_y_drive);
        end else begin
            // Deadzone: stop both pairs, hold the duties
            held_x_drive = DRIVE_STOP;
            held_y_drive = DRIVE_STOP;
        end
        cmd.x_duty  = held_x_duty;
        cmd.y_duty  = held_y_duty;
        cmd.x_drive = held_x_drive;
        cmd.y_drive = held_y_drive;
        return cmd;
    endfunction

    task automatic compare_field(input string field, input logic [DUTY_W-1:0] exp_val,
                                 input logic [DUTY_W-1:0] got_val);
        if (got_val !== exp_val) begin
            o_mismatches++;
            $display("%0t ns: %s expected %0d, got %0d", $time, field, exp_val, got_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            settings.center_x       = RST_CENTER_X;
            settings.center_y       = RST_CENTER_Y;
            settings.move_threshold = RST_MOVE_THRESHOLD;
            settings.speed_scale    = RST_SPEED_SCALE;
            settings.axis_deadband  = RST_AXIS_DEADBAND;
            settings.duty_min       = RST_DUTY_MIN;
            settings.duty_max       = RST_DUTY_MAX;
            held_x_duty  = '0;
            held_y_duty  = '0;
            held_x_drive = DRIVE_STOP;
            held_y_drive = DRIVE_STOP;
            pending_cmds.delete();
            o_mismatches = 0;
            o_checked    = 0;
        end else begin
            // Compare a returned transaction with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                seen.x_duty  = i_x_duty;
                seen.y_duty  = i_y_duty;
                seen.x_drive = i_x_drive;
                seen.y_drive = i_y_drive;
                if (pending_cmds.size() == 0) begin
                    o_mismatches++;
                    $display("%0t ns: result expected none, got %0d %0d %0d %0d",
                             $time, seen.x_duty, seen.y_duty, seen.x_drive,
                             seen.y_drive);
                end else begin
                    want = pending_cmds.pop_front();
                    compare_field("x_duty", want.x_duty, seen.x_duty);
                    compare_field("y_duty", want.y_duty, seen.y_duty);
                    compare_field("x_drive", DUTY_W'(want.x_drive), DUTY_W'(seen.x_drive));
                    compare_field("y_drive", DUTY_W'(want.y_drive), DUTY_W'(seen.y_drive));
                    o_checked++;
                end
            end

            // Predict the command for an accepted sample pair
            if (i_in_valid && i_in_ready)
                pending_cmds.push_back(next_drive_cmd(i_x_sample, i_y_sample));

            // Track register writes; unmapped indexes drop, data masks to width
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CENTER_X:       settings.center_x       = i_cfg_wdata[SAMPLE_W-1:0];
                    REG_CENTER_Y:       settings.center_y       = i_cfg_wdata[SAMPLE_W-1:0];
                    REG_MOVE_THRESHOLD: settings.move_threshold = i_cfg_wdata[THR_W-1:0];
                    REG_SPEED_SCALE:    settings.speed_scale    = i_cfg_wdata[SCALE_W-1:0];
                    REG_AXIS_DEADBAND:  settings.axis_deadband  = i_cfg_wdata[SAMPLE_W-1:0];
                    REG_DUTY_MIN:       settings.duty_min       = i_cfg_wdata[DUTY_W-1:0];
                    REG_DUTY_MAX:       settings.duty_max       = i_cfg_wdata[DUTY_W-1:0];
                    default: ;
                endcase
            end
        end
        o_outstanding = pending_cmds.size();
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// Top of the mapper testbench: clock, reset, stimulus, stalls and the verdict.
// Depends on jodm_pkg, omni_drive_checker and the joystick_omni_drive_mapper_unit RTL.
module testbench;
    import jodm_pkg::*;

    localparam int LIMIT_CYCLES    = 2000000;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 272;
    localparam int QUIET_PHASE     = 2;
    localparam int SETTLE_CYCLES   = 40;
    localparam int GAP_PERCENT     = 22;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [SAMPLE_W-1:0]   i_x_sample;
    logic [SAMPLE_W-1:0]   i_y_sample;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [DUTY_W-1:0]     o_x_duty;
    logic [DUTY_W-1:0]     o_y_duty;
    logic [DRIVE_W-1:0]    o_x_drive;
    logic [DRIVE_W-1:0]    o_y_drive;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    int mismatches;
    int outstanding;
    int checked;
    int cycle_count = 0;
    int samples_sent = 0;
    int settings_applied = 0;
    bit gaps_on;
    int cur_cx;
    int cur_cy;
    int cur_thr;
    int cur_db;

    joystick_omni_drive_mapper_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_x_sample  (i_x_sample),
        .i_y_sample  (i_y_sample),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_x_duty    (o_x_duty),
        .o_y_duty    (o_y_duty),
        .o_x_drive   (o_x_drive),
        .o_y_drive   (o_y_drive),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    omni_drive_checker drive_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_x_sample    (i_x_sample),
        .i_y_sample    (i_y_sample),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_x_duty      (o_x_duty),
        .i_y_duty      (o_y_duty),
        .i_x_drive     (o_x_drive),
        .i_y_drive     (o_y_drive),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("joystick_omni_drive_mapper_unit verification failed");
            $finish;
        end
    end

    // Result side: stall at random while gaps are on
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_out_ready <= 1'b0;
        else if (gaps_on && $urandom_range(99) < GAP_PERCENT)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= 1'b1;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic apply_settings(input int cx, input int cy, input int thr, input int scale,
                                  input int db, input int dmin, input int dmax);
        write_reg(REG_CENTER_X, CFG_DATA_W'(cx));
        write_reg(REG_CENTER_Y, CFG_DATA_W'(cy));
        write_reg(REG_MOVE_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(REG_SPEED_SCALE, CFG_DATA_W'(scale));
        write_reg(REG_AXIS_DEADBAND, CFG_DATA_W'(db));
        write_reg(REG_DUTY_MIN, CFG_DATA_W'(dmin));
        write_reg(REG_DUTY_MAX, CFG_DATA_W'(dmax));
        cur_cx  = cx;
        cur_cy  = cy;
        cur_thr = thr;
        cur_db  = db;
        settings_applied++;
    endtask

    // Present one sample pair and hold it until the transaction is taken
    task automatic push_sample(input logic [SAMPLE_W-1:0] xs, input logic [SAMPLE_W-1:0] ys);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_x_sample <= xs;
        i_y_sample <= ys;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        samples_sent++;
    endtask

    // Drop valid and hold off until every predicted command has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (outstanding == 0);
    endtask

    function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
        if (v < 0)
            return '0;
        if (v > 1023)
            return '1;
        return v[SAMPLE_W-1:0];
    endfunction

    // Mix of full-range samples, stick moves around the center and edge cases
    task automatic push_random_sample();
        int span;
        int ox;
        int oy;
        int sign;
        span = cur_thr + cur_db + 24;
        if (span > 1023)
            span = 1023;
        sign = $urandom_range(1) ? 1 : -1;
        case ($urandom_range(9))
            0, 1, 2, 3: push_sample(SAMPLE_W'($urandom_range(1023)),
                                    SAMPLE_W'($urandom_range(1023)));
            4, 5, 6, 7: begin
                ox = int'($urandom_range(2 * span)) - span;
                oy = int'($urandom_range(2 * span)) - span;
                push_sample(clamp_sample(cur_cx + ox), clamp_sample(cur_cy + oy));
            end
            8: begin
                // Sit on the threshold or the deadband edge of one axis
                ox = sign * ($urandom_range(1) ? cur_thr + int'($urandom_range(1))
                                               : cur_db + int'($urandom_range(1)));
                oy = int'($urandom_range(2)) - 1;
                if ($urandom_range(1))
                    push_sample(clamp_sample(cur_cx + ox), clamp_sample(cur_cy + oy));
                else
                    push_sample(clamp_sample(cur_cx + oy), clamp_sample(cur_cy + ox));
            end
            default: begin
                ox = int'($urandom_range(2)) - 1;
                oy = int'($urandom_range(2)) - 1;
                push_sample(clamp_sample(cur_cx + ox), clamp_sample(cur_cy + oy));
            end
        endcase
    endtask

    // Mostly plausible joystick setups, now and then values far outside them
    task automatic apply_random_settings();
        int cx;
        int cy;
        int thr;
        int scale;
        int db;
        cx    = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(380, 640);
        cy    = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(380, 640);
        thr   = ($urandom_range(9) == 0) ? $urandom_range(1447) : $urandom_range(60);
        scale = ($urandom_range(3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 255);
        db    = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(100);
        apply_settings(cx, cy, thr, scale, db, $urandom_range(1023), $urandom_range(1023));
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_x_sample  = '0;
        i_y_sample  = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_CENTER_X;
        i_cfg_wdata = '0;
        gaps_on     = 1'b1;
        cur_cx      = int'(RST_CENTER_X);
        cur_cy      = int'(RST_CENTER_Y);
        cur_thr     = int'(RST_MOVE_THRESHOLD);
        cur_db      = int'(RST_AXIS_DEADBAND);

        // Hold reset, then release it on a falling clock edge
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: deadzone, corners, held direction inside the deadband
        push_sample(10'd499, 10'd504);
        push_sample(10'd1023, 10'd0);
        push_sample(10'd509, 10'd518);
        push_sample(10'd514, 10'd504);
        push_sample(10'd509, 10'd518);
        push_sample(10'd515, 10'd504);
        push_sample(10'd0, 10'd1023);
        push_sample(10'h2AA, 10'h155);
        push_sample(10'h155, 10'h2AA);
        push_sample(10'd499, 10'd0);
        drain_results();

        // Zero threshold and deadband, full speed scale
        apply_settings(0, 0, 0, 255, 0, 0, 1023);
        push_sample(10'd0, 10'd0);
        push_sample(10'd1, 10'd0);
        push_sample(10'd1023, 10'd1023);
        push_sample(10'd0, 10'd1023);
        drain_results();

        // Unreachable threshold, zero scale, inverted duty range, masked and unmapped writes
        apply_settings(1023, 1023, 1447, 0, 1023, 1023, 0);
        write_reg(REG_CENTER_X, '1);
        write_reg(REG_UNMAPPED, '1);
        push_sample(10'd0, 10'd0);
        drain_results();
        write_reg(REG_MOVE_THRESHOLD, '0);
        push_sample(10'd0, 10'd0);
        push_sample(10'd1023, 10'd1023);
        drain_results();

        // Small scale with inverted duty range
        apply_settings(512, 512, 3, 7, 1, 1023, 0);
        push_sample(10'd1023, 10'd600);
        push_sample(10'd0, 10'd512);
        push_sample(10'd513, 10'd511);
        push_sample(10'd515, 10'd513);
        drain_results();

        // Random phases; one runs without any stalls on either side
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            gaps_on = (phase != QUIET_PHASE);
            apply_random_settings();
            repeat (ITEMS_PER_PHASE)
                push_random_sample();
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d sample pairs through %0d register setups, %0d commands compared.",
                 samples_sent, settings_applied, checked);
        $display("Setups spanned zero and full scale, inverted duties and a stall-free phase.");
        if (mismatches == 0 && outstanding == 0)
            $display("joystick_omni_drive_mapper_unit verification clean");
        else
            $display("joystick_omni_drive_mapper_unit verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/jodm_pkg.sv
sv/jodm_mulcmp.sv
sv/jodm_seq.sv
sv/joystick_omni_drive_mapper_unit.sv
verif/omni_drive_checker.sv
verif/testbench.sv
